@@ design/polm_pkg.sv @@
// Package with shared types and constants for the priority-ordered lock manager.
package polm_pkg;

  localparam int unsigned PID_W = 16;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned DEFAULT_QUEUE_DEPTH = 64;

  typedef logic [PID_W-1:0] pid_t;

  typedef enum logic {
    ACT_ACQUIRE = 1'b0,
    ACT_RELEASE = 1'b1
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_RELEASED    = 3'd0,
    ST_QUEUED      = 3'd1,
    ST_GRANTED     = 3'd2,
    ST_ALREADY_HLD = 3'd3,
    ST_NOT_HOLDER  = 3'd4,
    ST_LIST_FULL   = 3'd5
  } status_e;

  typedef struct packed {
    logic insert;
    logic pop;
    pid_t pid;
  } cell_ctrl_t;

endpackage

@@ design/polm_req_if.sv @@
// Request channel interface: valid/ready handshake with action and requester id.
interface polm_req_if
  import polm_pkg::*;
();
  logic    valid;
  logic    ready;
  action_e action;
  pid_t    requester_pid;

  modport source (output valid, output action, output requester_pid, input ready);
  modport sink (input valid, input action, input requester_pid, output ready);
endinterface

@@ design/polm_rsp_if.sv @@
// Response channel interface: valid/ready handshake with status, grant and waiter count.
interface polm_rsp_if
  import polm_pkg::*;
#(
  parameter int unsigned CNT_W = 7
) ();
  logic             valid;
  logic             ready;
  status_e          status;
  logic             grant_valid;
  pid_t             grant_pid;
  logic [CNT_W-1:0] waiting_count;

  modport source (output valid, output status, output grant_valid, output grant_pid,
                  output waiting_count, input ready);
  modport sink (input valid, input status, input grant_valid, input grant_pid,
                input waiting_count, output ready);
endinterface

@@ design/polm_cell.sv @@
// One slot of the sorted waiting list, shifting with its neighbors on insert and pop.
module polm_cell
  import polm_pkg::*;
(
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  logic       occupied_i,
  input  logic       left_keep_i,
  input  pid_t       left_pid_i,
  input  pid_t       right_pid_i,
  output logic       keep_o,
  output pid_t       pid_o
);

  pid_t pid_q, pid_d;

  assign keep_o = occupied_i && (pid_q > ctrl_i.pid);
  assign pid_o  = pid_q;

  always_comb begin
    pid_d = pid_q;
    if (ctrl_i.insert && !keep_o) begin
      pid_d = left_keep_i ? ctrl_i.pid : left_pid_i;
    end else if (ctrl_i.pop) begin
      pid_d = right_pid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pid_q <= pid_d;
  end

endmodule

@@ design/priority_ordered_lock_manager.sv @@
// Top level of the priority-ordered lock manager.
//
// Requests arrive on req_i (action and requester id) and each one produces
// exactly one response transaction on rsp_o (status, grant flag, granted id
// and the number of waiters after the request). The waiting list is a row of
// QUEUE_DEPTH cells sorted by descending id; an insert shifts the cells from
// the insertion point on by one place, and a pop shifts every cell one place
// toward the head. The response is registered and is valid in the cycle after
// the request is accepted, and one request is taken every cycle while the
// response register is empty or being drained. If the receiver stalls, the
// response is held in its output register and req_i.ready stays low until it
// is taken. Reset clears the lock, the holder id and the waiter count; the
// cell contents need no reset because only cells below the count are ever read.
module priority_ordered_lock_manager
  import polm_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  polm_req_if.sink    req_i,
  polm_rsp_if.source  rsp_o
);

  logic [CNT_W-1:0] count_q, count_d;
  logic             held_q, held_d;
  pid_t             holder_q, holder_d;

  logic             out_valid_q;
  status_e          status_q, status_d;
  logic             gvalid_q, gvalid_d;
  pid_t             gpid_q, gpid_d;

  logic             fire;
  logic             is_holder;
  cell_ctrl_t       ctrl;

  pid_t             cell_pid [QUEUE_DEPTH];
  logic             cell_keep [QUEUE_DEPTH];

  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign fire        = req_i.valid && req_i.ready;
  assign is_holder   = held_q && (holder_q == req_i.requester_pid);

  always_comb begin
    count_d    = count_q;
    held_d     = held_q;
    holder_d   = holder_q;
    status_d   = ST_NOT_HOLDER;
    gvalid_d   = 1'b0;
    gpid_d     = '0;
    ctrl.insert = 1'b0;
    ctrl.pop    = 1'b0;
    ctrl.pid    = req_i.requester_pid;
    if (req_i.action == ACT_ACQUIRE) begin
      if (is_holder) begin
        status_d = ST_ALREADY_HLD;
      end else if (count_q == CNT_W'(QUEUE_DEPTH)) begin
        status_d = ST_LIST_FULL;
      end else if (!held_q) begin
        status_d = ST_GRANTED;
        held_d   = 1'b1;
        holder_d = req_i.requester_pid;
        gvalid_d = 1'b1;
        gpid_d   = req_i.requester_pid;
      end else begin
        status_d    = ST_QUEUED;
        ctrl.insert = fire;
        count_d     = count_q + CNT_W'(1);
      end
    end else if (is_holder) begin
      status_d = ST_RELEASED;
      if (count_q != '0) begin
        ctrl.pop = fire;
        count_d  = count_q - CNT_W'(1);
        holder_d = cell_pid[0];
        gvalid_d = 1'b1;
        gpid_d   = cell_pid[0];
      end else begin
        held_d   = 1'b0;
        holder_d = '0;
      end
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic occupied;
    logic left_keep;
    pid_t left_pid;
    pid_t right_pid;

    assign occupied = CNT_W'(i) < count_q;

    if (i == 0) begin : g_first
      assign left_keep = 1'b0;
      assign left_pid  = req_i.requester_pid;
    end else begin : g_inner
      assign left_keep = cell_keep[i-1];
      assign left_pid  = cell_pid[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_pid = cell_pid[i];
    end else begin : g_mid
      assign right_pid = cell_pid[i+1];
    end

    polm_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occupied_i  (occupied),
      .left_keep_i (left_keep),
      .left_pid_i  (left_pid),
      .right_pid_i (right_pid),
      .keep_o      (cell_keep[i]),
      .pid_o       (cell_pid[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      held_q      <= 1'b0;
      holder_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        count_q  <= count_d;
        held_q   <= held_d;
        holder_q <= holder_d;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q <= status_d;
      gvalid_q <= gvalid_d;
      gpid_q   <= gpid_d;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = status_q;
  assign rsp_o.grant_valid   = gvalid_q;
  assign rsp_o.grant_pid     = gpid_q;
  assign rsp_o.waiting_count = count_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("Waiter count exceeds the queue depth.");

  a_free_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !held_q |-> count_q == '0)
    else $error("Waiters present while the lock is free.");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.insert |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("Insert did not increment the waiter count.");

  a_pop_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.pop |=> held_q && gvalid_q && (holder_q == gpid_q))
    else $error("Pop did not hand the lock to the head waiter.");

endmodule
